// ===== sv/date_interval_calculator_macros.svh =====
// ----------------------------------------------------------------------------
// Date interval calculator assertion macros
// Checks for the date interval calculator. When SYNTH is defined, the macros
// expand to nothing.
// ----------------------------------------------------------------------------
`ifndef DATE_INTERVAL_CALCULATOR_MACROS_SVH
`define DATE_INTERVAL_CALCULATOR_MACROS_SVH
`ifndef SYNTH
`define DIC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("date_interval_calculator: check failed");
`define DIC_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("date_interval_calculator: reset check failed");
`else
`define DIC_ASSERT(label, clk, rst_n, prop)
`define DIC_ASSERT_RST(label, clk, prop)
`endif
`endif

// ===== sv/dic_pkg.sv =====
// ----------------------------------------------------------------------------
// Date interval calculator package
// Shared types, constants and calendar tables.
// ----------------------------------------------------------------------------
package dic_pkg;

    localparam int DATE_W      = 27;
    localparam int DATE_STAGES = 5;
    localparam int STAGES      = 8;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 72;

    // Reciprocals for exact division by constants over the ranges in use.
    localparam logic [27:0] RECIP_10K = 28'd219902326;
    localparam logic [14:0] RECIP_100 = 15'd20972;
    localparam logic [22:0] RECIP_7   = 23'd4793491;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DATE = 2'd1,
        ST_ORDER    = 2'd2
    } status_t;

    typedef struct packed {
        logic [21:0] day_num;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  month_len;
        logic        valid;
    } date_info_t;

    function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        begin
            case (m)
                4'd2:                       n = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:    n = 5'd30;
                default:                    n = 5'd31;
            endcase
            return n;
        end
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] n;
        begin
            case (m)
                4'd2:    n = 9'd31;
                4'd3:    n = 9'd59;
                4'd4:    n = 9'd90;
                4'd5:    n = 9'd120;
                4'd6:    n = 9'd151;
                4'd7:    n = 9'd181;
                4'd8:    n = 9'd212;
                4'd9:    n = 9'd243;
                4'd10:   n = 9'd273;
                4'd11:   n = 9'd304;
                4'd12:   n = 9'd334;
                default: n = 9'd0;
            endcase
            return n;
        end
    endfunction

endpackage

// ===== sv/date_interval_calculator.sv =====
// ----------------------------------------------------------------------------
// Date interval calculator
// Days between two Gregorian DDMMYYYY dates, with week and rough
// year/month/day splits.
// ----------------------------------------------------------------------------
// The block takes one date pair per beat and can accept a new beat on every
// clock cycle unless back-pressure has filled all the stages. Each result is
// registered through the date units, where reciprocal multiplications extract
// the decimal digits and form the day numbers, then through the subtraction,
// the division by seven and the final split. Back-pressure on the output stalls
// only the stages that are full, so no beat is lost or repeated.
`include "date_interval_calculator_macros.svh"

module date_interval_calculator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // start_packed [26:0], end_packed [53:27], zero padding [55:54]
    input  logic [dic_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status [1:0], day_count [23:2], whole_weeks [42:24], week_leftover [45:43],
    // years_part [59:46], months_part [63:60], days_part [68:64], zero padding [71:69]
    output logic [dic_pkg::M_TDATA_W-1:0]   m_tdata
);
    import dic_pkg::*;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] en;
    date_info_t        s_info;
    date_info_t        e_info;

    status_t     status6_next;
    logic [21:0] total6_next;
    logic [13:0] years6_next;
    logic [4:0]  months6_next;
    logic [5:0]  left6_next;
    logic        same_y;
    logic        same_m;
    status_t     status6_reg;
    logic [21:0] total6_reg;
    logic [13:0] years6_reg;
    logic [4:0]  months6_reg;
    logic [5:0]  left6_reg;

    logic [44:0] prod7;
    logic        lq7;
    status_t     status7_reg;
    logic [21:0] total7_reg;
    logic [18:0] weeks7_reg;
    logic [13:0] years7_reg;
    logic [4:0]  mtmp7_reg;
    logic [4:0]  days7_reg;

    logic [21:0] w7;
    status_t     status8_reg;
    logic [21:0] total8_reg;
    logic [18:0] weeks8_reg;
    logic [2:0]  leftover8_reg;
    logic [13:0] years8_reg;
    logic [3:0]  months8_reg;
    logic [4:0]  days8_reg;

    always_comb
    begin
        en[STAGES-1] = !v_reg[STAGES-1] || m_tready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    dic_date_unit u_start (
        .clk       (clk),
        .en        (en[DATE_STAGES-1:0]),
        .date_word (s_tdata[DATE_W-1:0]),
        .info      (s_info)
    );

    dic_date_unit u_end (
        .clk       (clk),
        .en        (en[DATE_STAGES-1:0]),
        .date_word (s_tdata[2*DATE_W-1:DATE_W]),
        .info      (e_info)
    );

    assign same_y = (s_info.year == e_info.year);
    assign same_m = (s_info.month == e_info.month);

    always_comb
    begin
        total6_next  = e_info.day_num - s_info.day_num;
        years6_next  = 14'd0;
        months6_next = 5'd0;
        left6_next   = 6'(s_info.month_len) - 6'(s_info.day) + 6'(e_info.day);
        if (same_y && same_m)
        begin
            left6_next = 6'(e_info.day) - 6'(s_info.day);
        end
        else if (same_y)
        begin
            months6_next = 5'(e_info.month) - 5'(s_info.month) - 5'd1;
        end
        else
        begin
            years6_next  = e_info.year - s_info.year - 14'd1;
            months6_next = (5'd12 - 5'(s_info.month)) + (5'(e_info.month) - 5'd1);
        end
        if (!(s_info.valid && e_info.valid))
        begin
            status6_next = ST_BAD_DATE;
        end
        else if (e_info.day_num < s_info.day_num)
        begin
            status6_next = ST_ORDER;
        end
        else
        begin
            status6_next = ST_OK;
        end
        if (status6_next != ST_OK)
        begin
            total6_next  = 22'd0;
            years6_next  = 14'd0;
            months6_next = 5'd0;
            left6_next   = 6'd0;
        end
    end

    assign prod7 = 45'(total6_reg) * 45'(RECIP_7);
    assign lq7   = (left6_reg >= 6'd31);
    assign w7    = 22'(weeks7_reg) * 22'(3'd7);

    always_ff @(posedge clk)
    begin
        if (en[DATE_STAGES])
        begin
            status6_reg <= status6_next;
            total6_reg  <= total6_next;
            years6_reg  <= years6_next;
            months6_reg <= months6_next;
            left6_reg   <= left6_next;
        end
        if (en[DATE_STAGES+1])
        begin
            status7_reg <= status6_reg;
            total7_reg  <= total6_reg;
            weeks7_reg  <= prod7[43:25];
            years7_reg  <= years6_reg + 14'(months6_reg >= 5'd12);
            mtmp7_reg   <= months6_reg + 5'(lq7);
            days7_reg   <= lq7 ? 5'(left6_reg - 6'd31) : left6_reg[4:0];
        end
        if (en[DATE_STAGES+2])
        begin
            status8_reg   <= status7_reg;
            total8_reg    <= total7_reg;
            weeks8_reg    <= weeks7_reg;
            leftover8_reg <= 3'(total7_reg - w7);
            years8_reg    <= years7_reg;
            months8_reg   <= (mtmp7_reg >= 5'd12) ? 4'(mtmp7_reg - 5'd12) : mtmp7_reg[3:0];
            days8_reg     <= days7_reg;
        end
    end

    assign m_tdata = {3'd0, days8_reg, months8_reg, years8_reg, leftover8_reg,
                      weeks8_reg, total8_reg, status8_reg};

    `DIC_ASSERT(a_err_zero, clk, rst_n, (m_tvalid && status8_reg != ST_OK) |-> (m_tdata[71:2] == 70'd0))
    `DIC_ASSERT(a_split_range, clk, rst_n, (m_tvalid && status8_reg == ST_OK) |-> (leftover8_reg < 3'd7 && months8_reg < 4'd12 && days8_reg < 5'd31))
    `DIC_ASSERT(a_weeks_exact, clk, rst_n, (m_tvalid && status8_reg == ST_OK) |-> (23'(weeks8_reg) * 23'd7 + 23'(leftover8_reg) == 23'(total8_reg)))
    `DIC_ASSERT(a_ready_on_bubble, clk, rst_n, (v_reg != {STAGES{1'b1}}) |-> s_tready)
    `DIC_ASSERT_RST(a_reset_empty, clk, !rst_n |=> !m_tvalid)

endmodule

// ===== sv/dic_date_unit.sv =====
// ----------------------------------------------------------------------------
// Date unit
// Splits one DDMMYYYY word into day, month and year, checks it and forms its
// day number, over five register stages.
// ----------------------------------------------------------------------------
module dic_date_unit (
    input  logic                              clk,
    input  logic [dic_pkg::DATE_STAGES-1:0]   en,
    input  logic [dic_pkg::DATE_W-1:0]        date_word,
    output dic_pkg::date_info_t               info
);
    import dic_pkg::*;

    logic [54:0] prod1;
    logic [13:0] q1_next;
    logic [13:0] q1_reg;
    logic [13:0] plo1_reg;

    logic [27:0] prod2a;
    logic [28:0] prod2b;
    logic [13:0] year2_next;
    logic [7:0]  q100_2_next;
    logic [13:0] year2_reg;
    logic [6:0]  qlo2_reg;
    logic [7:0]  q100_2_reg;

    logic [13:0] prod3a;
    logic [28:0] prod3b;
    logic [6:0]  mm3_next;
    logic [6:0]  dd3_next;
    logic [6:0]  yc3_next;
    logic [13:0] year3_reg;
    logic [6:0]  mm3_reg;
    logic [6:0]  dd3_reg;
    logic [6:0]  yc3_reg;

    logic [13:0] prod4;
    logic [6:0]  r4;
    logic        leap4;
    logic        rem4;
    logic [4:0]  mlen4_next;
    logic        valid4_next;
    logic [11:0] lb4_next;
    logic [8:0]  dbf4_next;
    logic [13:0] year4_reg;
    logic [3:0]  mm4_reg;
    logic [4:0]  dd4_reg;
    logic [4:0]  mlen4_reg;
    logic        valid4_reg;
    logic [11:0] lb4_reg;
    logic [8:0]  dbf4_reg;

    logic [21:0] dn5_next;
    date_info_t  info5_reg;

    assign prod1   = 55'(date_word) * 55'(RECIP_10K);
    assign q1_next = prod1[54:41];

    assign prod2a      = 28'(q1_reg) * 28'(14'd10000);
    assign prod2b      = 29'(q1_reg) * 29'(RECIP_100);
    assign year2_next  = plo1_reg - prod2a[13:0];
    assign q100_2_next = prod2b[28:21];

    assign prod3a   = 14'(q100_2_reg) * 14'(7'd100);
    assign prod3b   = 29'(year2_reg) * 29'(RECIP_100);
    assign mm3_next = qlo2_reg - prod3a[6:0];
    assign dd3_next = (q100_2_reg >= 8'd100) ? 7'(q100_2_reg - 8'd100) : q100_2_reg[6:0];
    assign yc3_next = prod3b[27:21];

    assign prod4       = 14'(yc3_reg) * 14'(7'd100);
    assign r4          = year3_reg[6:0] - prod4[6:0];
    assign rem4        = (r4 != 7'd0);
    assign leap4       = (year3_reg[1:0] == 2'd0) && (rem4 || (yc3_reg[1:0] == 2'd0));
    assign mlen4_next  = month_length(mm3_reg[3:0], leap4);
    assign valid4_next = (mm3_reg >= 7'd1) && (mm3_reg <= 7'd12) && (dd3_reg >= 7'd1)
                         && (dd3_reg <= 7'(mlen4_next));
    assign lb4_next    = 12'((15'(year3_reg) + 15'd3) >> 2) - 12'(yc3_reg) - 12'(rem4)
                         + 12'(yc3_reg >> 2) + 12'(rem4 || (yc3_reg[1:0] != 2'd0));
    assign dbf4_next   = days_before(mm3_reg[3:0])
                         + 9'((mm3_reg > 7'd2) && leap4);

    assign dn5_next = 22'(year4_reg) * 22'(9'd365) + 22'(lb4_reg) + 22'(dbf4_reg)
                      + 22'(dd4_reg);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            q1_reg   <= q1_next;
            plo1_reg <= date_word[13:0];
        end
        if (en[1])
        begin
            year2_reg  <= year2_next;
            qlo2_reg   <= q1_reg[6:0];
            q100_2_reg <= q100_2_next;
        end
        if (en[2])
        begin
            year3_reg <= year2_reg;
            mm3_reg   <= mm3_next;
            dd3_reg   <= dd3_next;
            yc3_reg   <= yc3_next;
        end
        if (en[3])
        begin
            year4_reg  <= year3_reg;
            mm4_reg    <= mm3_reg[3:0];
            dd4_reg    <= dd3_reg[4:0];
            mlen4_reg  <= mlen4_next;
            valid4_reg <= valid4_next;
            lb4_reg    <= lb4_next;
            dbf4_reg   <= dbf4_next;
        end
        if (en[4])
        begin
            info5_reg.day_num   <= dn5_next;
            info5_reg.year      <= year4_reg;
            info5_reg.month     <= mm4_reg;
            info5_reg.day       <= dd4_reg;
            info5_reg.month_len <= mlen4_reg;
            info5_reg.valid     <= valid4_reg;
        end
    end

    assign info = info5_reg;

endmodule

// ===== bench/date_interval_calculator_tb.sv =====
// ----------------------------------------------------------------------------
// Date interval calculator testbench
// Drives pairs of DDMMYYYY dates into the block and checks each result beat
// field by field against a calendar model held in the bench. Directed dates
// cover the field extremes, invalid dates, the date order and every case of
// the rough year/month/day split. Random pairs then run under several
// patterns of source idling and sink back-pressure.
// ----------------------------------------------------------------------------
module date_interval_calculator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dic_pkg::*;

    typedef struct packed {
        logic [2:0]  pad;
        logic [4:0]  days_part;
        logic [3:0]  months_part;
        logic [13:0] years_part;
        logic [2:0]  week_leftover;
        logic [18:0] whole_weeks;
        logic [21:0] day_count;
        status_t     status;
    } interval_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    interval_t interval_q[$];
    int        src_idle_pct = 0;
    int        sink_stall_pct = 0;
    int        errors = 0;
    int        n_ok = 0;
    int        n_bad_date = 0;
    int        n_order = 0;

    date_interval_calculator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit is_leap(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
        int unsigned n;
        case (m)
            2:            n = is_leap(y) ? 29 : 28;
            4, 6, 9, 11:  n = 30;
            default:      n = 31;
        endcase
        return n;
    endfunction

    function automatic int unsigned day_index(input int unsigned d, input int unsigned m,
                                              input int unsigned y);
        int unsigned n;
        n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + d;
        for (int unsigned k = 1; k < m; k++)
            n += days_in_month(k, 1);
        if (m > 2 && is_leap(y))
            n += 1;
        return n;
    endfunction

    function automatic interval_t predict_interval(input logic [26:0] sp, input logic [26:0] ep);
        int unsigned sy, sm, sd, ey, em, ed, a, b, total, years, months, left;
        interval_t   r;
        r = '0;
        sy = sp % 10000;
        sm = (sp / 10000) % 100;
        sd = (sp / 1000000) % 100;
        ey = ep % 10000;
        em = (ep / 10000) % 100;
        ed = (ep / 1000000) % 100;
        years = 0;
        months = 0;
        left = 0;
        if (sm < 1 || sm > 12 || em < 1 || em > 12)
            r.status = ST_BAD_DATE;
        else if (sd < 1 || sd > days_in_month(sm, sy) || ed < 1 || ed > days_in_month(em, ey))
            r.status = ST_BAD_DATE;
        else
        begin
            a = day_index(sd, sm, sy);
            b = day_index(ed, em, ey);
            if (b < a)
                r.status = ST_ORDER;
            else
            begin
                total = b - a;
                if (sy == ey && sm == em)
                    left = ed - sd;
                else if (sy == ey)
                begin
                    months = em - sm - 1;
                    left = days_in_month(sm, sy) - sd + ed;
                end
                else
                begin
                    years = ey - sy - 1;
                    months = (12 - sm) + (em - 1);
                    left = days_in_month(sm, sy) - sd + ed;
                end
                r.status = ST_OK;
                r.day_count = 22'(total);
                r.whole_weeks = 19'(total / 7);
                r.week_leftover = 3'(total % 7);
                r.years_part = 14'(years + months / 12);
                r.months_part = 4'((months + left / 31) % 12);
                r.days_part = 5'(left % 31);
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned got_v);
        if (exp_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            errors++;
        end
    endtask

    task automatic check_interval(input interval_t exp_r, input interval_t got_r);
        check_field("status", exp_r.status, got_r.status);
        check_field("day_count", exp_r.day_count, got_r.day_count);
        check_field("whole_weeks", exp_r.whole_weeks, got_r.whole_weeks);
        check_field("week_leftover", exp_r.week_leftover, got_r.week_leftover);
        check_field("years_part", exp_r.years_part, got_r.years_part);
        check_field("months_part", exp_r.months_part, got_r.months_part);
        check_field("days_part", exp_r.days_part, got_r.days_part);
        check_field("padding", 0, got_r.pad);
        case (exp_r.status)
            ST_OK:       n_ok++;
            ST_BAD_DATE: n_bad_date++;
            default:     n_order++;
        endcase
    endtask

    // Expectations are queued before results are checked, so ordering within
    // the clock edge cannot matter.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                interval_q.push_back(predict_interval(s_tdata[26:0], s_tdata[53:27]));
            if (m_tvalid && m_tready)
            begin
                if (interval_q.size() == 0)
                begin
                    $error("result beat with no date pair outstanding");
                    errors++;
                end
                else
                    check_interval(interval_q.pop_front(), interval_t'(m_tdata));
            end
        end
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    function automatic logic [26:0] ddmmyyyy(input int unsigned d, input int unsigned m,
                                             input int unsigned y);
        return 27'(d * 1000000 + m * 10000 + y);
    endfunction

    task automatic send_dates(input logic [26:0] sp, input logic [26:0] ep);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, ep, sp};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic test_field_extremes();
        send_dates(27'd0, 27'd0);
        send_dates(27'h7FFFFFF, 27'h7FFFFFF);
        send_dates(27'd99999999, 27'd99999999);
        send_dates(ddmmyyyy(1, 1, 0), ddmmyyyy(31, 12, 9999));
        send_dates(ddmmyyyy(1, 1, 0), ddmmyyyy(1, 1, 1));
        send_dates(ddmmyyyy(1, 1, 2000) + 27'd100000000, ddmmyyyy(1, 1, 2001));
    endtask

    task automatic test_invalid_dates();
        send_dates(ddmmyyyy(29, 2, 2023), ddmmyyyy(1, 3, 2023));
        send_dates(ddmmyyyy(29, 2, 1900), ddmmyyyy(1, 3, 1900));
        send_dates(ddmmyyyy(1, 13, 2020), ddmmyyyy(1, 1, 2021));
        send_dates(ddmmyyyy(0, 5, 2020), ddmmyyyy(1, 6, 2020));
        send_dates(ddmmyyyy(32, 1, 2020), ddmmyyyy(1, 2, 2020));
        send_dates(ddmmyyyy(31, 4, 2021), ddmmyyyy(1, 5, 2021));
        send_dates(ddmmyyyy(1, 1, 2000), ddmmyyyy(30, 2, 2000));
        send_dates(ddmmyyyy(29, 2, 2000), ddmmyyyy(29, 2, 2004));
        send_dates(ddmmyyyy(29, 2, 0), ddmmyyyy(1, 3, 0));
    endtask

    task automatic test_date_order();
        send_dates(ddmmyyyy(31, 12, 9999), ddmmyyyy(1, 1, 0));
        send_dates(ddmmyyyy(20, 5, 2020), ddmmyyyy(10, 5, 2020));
        send_dates(ddmmyyyy(1, 1, 2001), ddmmyyyy(31, 12, 2000));
        send_dates(ddmmyyyy(15, 6, 2024), ddmmyyyy(15, 6, 2024));
    endtask

    task automatic test_split_cases();
        send_dates(ddmmyyyy(3, 5, 2023), ddmmyyyy(28, 5, 2023));
        send_dates(ddmmyyyy(31, 1, 2023), ddmmyyyy(1, 3, 2023));
        send_dates(ddmmyyyy(31, 1, 2020), ddmmyyyy(1, 2, 2020));
        send_dates(ddmmyyyy(15, 8, 1999), ddmmyyyy(10, 2, 2024));
        send_dates(ddmmyyyy(1, 12, 2019), ddmmyyyy(31, 1, 2020));
    endtask

    function automatic logic [26:0] random_date(input int unsigned y);
        int unsigned m;
        logic [26:0] v;
        m = $urandom_range(12, 1);
        v = ddmmyyyy($urandom_range(days_in_month(m, y), 1), m, y);
        if ($urandom_range(3) == 0 && v < 27'd34217728)
            v += 27'd100000000;
        return v;
    endfunction

    task automatic test_random_pairs(input int n, input int idle_pct, input int stall_pct);
        int unsigned sy, ey, kind, m, d;
        logic [26:0] sp, ep;
        src_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        repeat (n)
        begin
            kind = $urandom_range(99);
            sy = $urandom_range(9999);
            sp = random_date(sy);
            if (kind < 15)
            begin
                m = (sp / 10000) % 100;
                ep = ddmmyyyy($urandom_range(days_in_month(m, sy), 1), m, sy);
            end
            else if (kind < 30)
                ep = random_date(sy);
            else if (kind < 65)
            begin
                ey = (sy < 9999) ? $urandom_range(9999, sy + 1) : sy;
                if ($urandom_range(1) == 0 && sy < 9990)
                    ey = sy + $urandom_range(9, 1);
                ep = random_date(ey);
            end
            else if (kind < 75)
            begin
                ep = sp;
                sp = random_date((sy < 9999) ? $urandom_range(9999, sy + 1) : sy);
            end
            else if (kind < 85)
            begin
                ep = random_date($urandom_range(9999, sy));
                d = $urandom_range(99);
                m = $urandom_range(1) ? $urandom_range(99) : $urandom_range(12, 1);
                if ($urandom_range(1))
                    sp = ddmmyyyy(d, m, sy);
                else
                    ep = ddmmyyyy(d, m, ep % 10000);
            end
            else
            begin
                sp = 27'($urandom);
                ep = 27'($urandom);
            end
            send_dates(sp, ep);
        end
    endtask

    initial
    begin
        int waited;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_invalid_dates();
        test_date_order();
        test_split_cases();
        test_random_pairs(200, 0, 0);
        test_random_pairs(200, 53, 0);
        test_random_pairs(200, 0, 53);
        test_random_pairs(200, 36, 36);
        s_tvalid <= 1'b0;
        waited = 0;
        while (interval_q.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (interval_q.size() != 0)
        begin
            $error("%0d results never arrived", interval_q.size());
            errors++;
        end
        $display("Checked %0d result beats: %0d valid intervals, %0d bad dates, %0d reversed.",
                 n_ok + n_bad_date + n_order, n_ok, n_bad_date, n_order);
        $display("Random pairs ran with no idling, source gaps, sink stalls and both.");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/dic_pkg.sv
sv/dic_date_unit.sv
sv/date_interval_calculator.sv
bench/date_interval_calculator_tb.sv
